>>> src/lru_key_value_cache_unit_macros.svh
// Assertion macros shared by the cache checker.
// No dependencies; included by lkvc_checker.sv.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// Property checked on rising clk, disabled while reset is low.
`define LKVC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lkvc assertion failed");

// Stalled valid holds and payload stays put.
`define LKVC_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `LKVC_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

>>> src/lkvc_pkg.sv
// Package for the LRU key-value cache: sizes, codes and state type.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCAN_W      = CNT_W;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = KEY_W + VAL_W;
  localparam int IN_DATA_W   = KEY_W + VAL_W;
  localparam int OUT_DATA_W  = VAL_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } lkvc_state_e;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;

endpackage

>>> src/lru_key_value_cache_unit.sv
// Fully associative LRU key-value cache, one request at a time.
// A get's result is presented from the decide state once the result channel is free.
// Requests are served one at a time, by a scan of one entry per cycle
// through the key/value RAM and its single key comparator.
// Reset: asynchronous, active low; clears valid marks, ranks, count; capacity 16.
// Uses lkvc_pkg and lkvc_ram.
`timescale 1ns / 1ps

module lru_key_value_cache_unit
  import lkvc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic                  s_axis_tuser,   // [0] kind
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] read_value
  output logic                  m_axis_tuser,   // [0] hit
  // capacity register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CAP_W-1:0]      cfg_data_i
);

  lkvc_state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  rank_t rank_q [MAX_ENTRIES];
  rank_t rank_d [MAX_ENTRIES];

  logic              kind_q, kind_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  val_q, val_d;

  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              cmp_en_q, cmp_en_d;
  idx_t              cmp_idx_q, cmp_idx_d;

  logic              found_q, found_d;
  idx_t              found_idx_q, found_idx_d;
  logic [VAL_W-1:0]  hit_val_q, hit_val_d;
  logic              free_q, free_d;
  idx_t              free_idx_q, free_idx_d;
  logic              lru_q, lru_d;
  idx_t              lru_idx_q, lru_idx_d;
  rank_t             lru_rank_q, lru_rank_d;

  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;

  logic               ram_we;
  idx_t               ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  idx_t               ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;

  logic [CNT_W-1:0]  eff_cap;
  logic              in_req;
  logic              promote;
  idx_t              prom_idx;
  rank_t             prom_limit;
  logic              prom_all;

  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_hit_q;

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_val = ram_rdata[ENTRY_W-1:KEY_W];

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  lkvc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = scan_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    valid_d     = valid_q;
    kind_d      = kind_q;
    key_d       = key_q;
    val_d       = val_q;
    scan_d      = scan_q;
    cmp_en_d    = 1'b0;
    cmp_idx_d   = scan_q[IDX_W-1:0];
    found_d     = found_q;
    found_idx_d = found_idx_q;
    hit_val_d   = hit_val_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    lru_d       = lru_q;
    lru_idx_d   = lru_idx_q;
    lru_rank_d  = lru_rank_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_val_d   = out_val_q;
    ram_we      = 1'b0;
    ram_waddr   = found_idx_q;
    ram_wdata   = {val_q, key_q};
    promote     = 1'b0;
    prom_idx    = found_idx_q;
    prom_limit  = rank_q[found_idx_q];
    prom_all    = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // scan compare, one entry per cycle
    if (cmp_en_q && valid_q[cmp_idx_q]) begin
      if (!found_q && rd_key == key_q) begin
        found_d     = 1'b1;
        found_idx_d = cmp_idx_q;
        hit_val_d   = rd_val;
      end
      if (!lru_q || rank_q[cmp_idx_q] > lru_rank_q) begin
        lru_d      = 1'b1;
        lru_idx_d  = cmp_idx_q;
        lru_rank_d = rank_q[cmp_idx_q];
      end
    end else if (cmp_en_q && !free_q) begin
      free_d     = 1'b1;
      free_idx_d = cmp_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          kind_d  = s_axis_tuser;
          key_d   = s_axis_tdata[KEY_W-1:0];
          val_d   = s_axis_tdata[IN_DATA_W-1:KEY_W];
          scan_d  = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          lru_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (32'(scan_q) < MAX_ENTRIES) begin
          cmp_en_d = 1'b1;
          scan_d   = scan_q + SCAN_W'(1);
        end else if (cmp_en_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (kind_q == KIND_GET) begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d = 1'b1;
            out_hit_d   = found_q;
            out_val_d   = found_q ? hit_val_q : MISS_VALUE;
            promote     = found_q;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
          if (found_q) begin
            ram_we  = 1'b1;
            promote = 1'b1;
          end else if (occ_q < eff_cap && free_q) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_q;
            occ_d     = occ_q + CNT_W'(1);
          end else if (lru_q) begin
            ram_we    = 1'b1;
            ram_waddr = lru_idx_q;
          end else if (free_q) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_q;
            occ_d     = occ_q + CNT_W'(1);
          end
          if (ram_we && !found_q) begin
            valid_d[ram_waddr] = 1'b1;
            promote            = 1'b1;
            prom_idx           = ram_waddr;
            prom_all           = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (promote) begin
        if (IDX_W'(i) == prom_idx) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (prom_all || rank_q[i] < prom_limit)) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      valid_q     <= '0;
      scan_q      <= '0;
      cmp_en_q    <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      lru_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      cmp_en_q    <= cmp_en_d;
      found_q     <= found_d;
      free_q      <= free_d;
      lru_q       <= lru_d;
      out_valid_q <= out_valid_d;
      rank_q      <= rank_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    val_q       <= val_d;
    cmp_idx_q   <= cmp_idx_d;
    found_idx_q <= found_idx_d;
    hit_val_q   <= hit_val_d;
    free_idx_q  <= free_idx_d;
    lru_idx_q   <= lru_idx_d;
    lru_rank_q  <= lru_rank_d;
    out_hit_q   <= out_hit_d;
    out_val_q   <= out_val_d;
  end

endmodule

>>> src/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lkvc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/lkvc_checker.sv
// Port-level checker for the LRU cache, bound to the top level.
// Uses lkvc_pkg and lru_key_value_cache_unit_macros.svh.
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_macros.svh"

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // a request keeps the input side busy for the scan
  `LKVC_ASSERT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> (!s_axis_tready)[*2])
  `LKVC_ASSERT_HOLD(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `LKVC_ASSERT_HOLD(a_out_hit_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tuser)
  // miss returns all ones
  `LKVC_ASSERT(a_miss, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == MISS_VALUE)

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
